/* rtl/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console cursor and scroll core.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Character codes with special handling
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Tab expands to this many spaces
  localparam int TAB_SPACES = 4;
  localparam int TAB_W      = $clog2(TAB_SPACES + 1);

  // Screen contents after reset: space in color 7
  localparam logic [7:0]  COLOR_RESET = 8'h07;
  localparam logic [15:0] CELL_RESET  = {COLOR_RESET, CH_SPACE};

  // Request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // One request
  typedef struct packed {
    logic        func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
    logic        end_of_write;
  } tcc_req_t;

  // One result
  typedef struct packed {
    logic [15:0] cell_word;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        write_done;
  } tcc_rsp_t;

  // Cursor operations
  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_BACK,
    CUR_NEWLINE,
    CUR_ADVANCE
  } cur_op_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_PUT,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

/* rtl/text_console_cursor_scroll_core.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Character-cell text console: screen memory, cursor, tab expansion and
// scrolling, driven one request at a time by a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   signals              direction  transfer
//  request   start, busy, req     in         start high and busy low
//  result    done, rsp            out        done high for one cycle
//  color     cfg_we, cfg_data     in         cfg_we high
//
// A plain character goes through dispatch, put and done; a cell read goes
// through read address, read data and done; backspace and a newline without
// scroll through dispatch and done; a tab repeats put once per space. A scroll
// moves the screen rows up through the single read and write port, a read and
// then a write per cell, and fills the bottom row. After reset a clearing pass
// writes spaces in color 7 while busy is high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core import tcc_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  tcc_req_t   req,
  output logic       done,
  output tcc_rsp_t   rsp,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int FILL_BASE = (ROWS - 1) * COLUMNS;

  state_t           state;
  state_t           state_next;
  tcc_req_t         req_q;
  logic [7:0]       text_color;
  logic [AW-1:0]    ptr;
  logic [TAB_W-1:0] puts_left;
  logic [15:0]      word;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [15:0]      ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [15:0]      ram_rdata;

  cur_op_t          cur_op;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [AW-1:0]    cur_pos;
  logic             cur_scroll;

  logic [31:0]      idx_wide;
  logic             idx_in_range;
  logic [31:0]      col_wide;
  logic [31:0]      row_wide;
  logic             ptr_last;
  logic [7:0]       put_char;

  assign idx_wide     = 32'(req_q.cell_index);
  assign idx_in_range = (idx_wide < 32'(CELLS));
  assign col_wide     = 32'(cur_col);
  assign row_wide     = 32'(cur_row);
  assign ptr_last     = (ptr == AW'(CELLS - 1));
  assign put_char     = (req_q.char_code == CH_TAB) ? CH_SPACE : req_q.char_code;
  assign busy         = (state != ST_IDLE);

  tcc_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcc_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk    (clk),
    .rst    (rst),
    .op     (cur_op),
    .col    (cur_col),
    .row    (cur_row),
    .pos    (cur_pos),
    .scroll (cur_scroll)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (ptr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = (req.func == FUNC_READ) ? ST_RD_ADDR : ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (req_q.char_code)
          CH_BS:   state_next = ST_DONE;
          CH_NL:   state_next = cur_scroll ? ST_SCR_RD : ST_DONE;
          default: state_next = ST_PUT;
        endcase
      end
      ST_RD_ADDR: state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = ST_DONE;
      ST_PUT: begin
        if (cur_scroll) begin
          state_next = ST_SCR_RD;
        end else if (puts_left == TAB_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_SCR_RD: state_next = ST_SCR_WR;
      ST_SCR_WR: state_next = ptr_last ? ST_FILL : ST_SCR_RD;
      ST_FILL: begin
        if (ptr_last) begin
          state_next = (puts_left == '0) ? ST_DONE : ST_PUT;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port and cursor controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = {text_color, CH_SPACE};
    ram_raddr = ptr;
    cur_op    = CUR_HOLD;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = CELL_RESET;
      end
      ST_DISPATCH: begin
        case (req_q.char_code)
          CH_BS:   cur_op = CUR_BACK;
          CH_NL:   cur_op = CUR_NEWLINE;
          default: cur_op = CUR_HOLD;
        endcase
      end
      ST_RD_ADDR: begin
        ram_raddr = idx_wide[AW-1:0];
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cur_pos;
        ram_wdata = {text_color, put_char};
        cur_op    = CUR_ADVANCE;
      end
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr - AW'(COLUMNS);
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Hold the text color
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_RESET;
    end else if (cfg_we) begin
      text_color <= cfg_data;
    end
  end

  // Address counter and put count
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      puts_left <= '0;
    end else begin
      case (state)
        ST_CLEAR: ptr <= ptr + AW'(1);
        ST_DISPATCH: begin
          ptr <= AW'(COLUMNS);
          case (req_q.char_code)
            CH_TAB:  puts_left <= TAB_W'(TAB_SPACES);
            CH_BS:   puts_left <= '0;
            CH_NL:   puts_left <= '0;
            default: puts_left <= TAB_W'(1);
          endcase
        end
        ST_PUT: begin
          ptr       <= AW'(COLUMNS);
          puts_left <= puts_left - TAB_W'(1);
        end
        ST_SCR_WR: ptr <= ptr_last ? AW'(FILL_BASE) : ptr + AW'(1);
        ST_FILL:   ptr <= ptr + AW'(1);
        default:   ptr <= ptr;
      endcase
    end
  end

  // Capture the request and the read word
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_q <= req;
      word  <= '0;
    end else if (state == ST_RD_DATA) begin
      word <= idx_in_range ? ram_rdata : '0;
    end
  end

  // Drive the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      rsp.cell_word  <= word;
      rsp.cursor_col <= col_wide[6:0];
      rsp.cursor_row <= row_wide[4:0];
      rsp.write_done <= req_q.end_of_write;
    end
  end

endmodule

/* rtl/tcc_ram.sv */
// ----------------------------------------------------------------------------
// tcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcc_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 2000,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tcc_cursor.sv */
// ----------------------------------------------------------------------------
// tcc_cursor
// Cursor position registers with back, newline and advance steps, and the
// linear cell address of the cursor.
// ----------------------------------------------------------------------------
module tcc_cursor import tcc_pkg::*; #(
  parameter int  COLUMNS = DEF_COLUMNS,
  parameter int  ROWS    = DEF_ROWS,
  localparam int COL_W   = $clog2(COLUMNS),
  localparam int ROW_W   = $clog2(ROWS),
  localparam int AW      = $clog2(COLUMNS * ROWS)
) (
  input  logic             clk,
  input  logic             rst,
  input  cur_op_t          op,
  output logic [COL_W-1:0] col,
  output logic [ROW_W-1:0] row,
  output logic [AW-1:0]    pos,
  output logic             scroll
);

  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             last_col;
  logic             last_row;

  assign last_col = (col == COL_W'(COLUMNS - 1));
  assign last_row = (row == ROW_W'(ROWS - 1));

  // Linear cell address of the cursor
  assign pos = AW'(AW'(row) * AW'(COLUMNS)) + AW'(col);

  // Step the cursor; flag a scroll when it would leave the bottom row
  always_comb begin
    col_next = col;
    row_next = row;
    scroll   = 1'b0;
    case (op)
      CUR_BACK: begin
        if (col != '0) begin
          col_next = col - COL_W'(1);
        end else if (row != '0) begin
          row_next = row - ROW_W'(1);
          col_next = COL_W'(COLUMNS - 1);
        end
      end
      CUR_NEWLINE: begin
        col_next = '0;
        if (last_row) begin
          scroll = 1'b1;
        end else begin
          row_next = row + ROW_W'(1);
        end
      end
      CUR_ADVANCE: begin
        if (last_col) begin
          col_next = '0;
          if (last_row) begin
            scroll = 1'b1;
          end else begin
            row_next = row + ROW_W'(1);
          end
        end else begin
          col_next = col + COL_W'(1);
        end
      end
      default: begin
        col_next = col;
        row_next = row;
      end
    endcase
  end

  // Hold the position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

/* test/tb_text_console_cursor_scroll_core.sv */
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll_core
// Self-checking bench for the text console core. A request-level shadow of the
// screen, cursor and color register predicts each result. Directed requests
// cover reset contents, out-of-range reads, control characters, wrap and
// scroll. Random write calls and cell reads, under bursty pacing and several
// color settings, follow.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll_core import tcc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS   = DEF_COLUMNS;
  localparam int LINES  = DEF_ROWS;
  localparam int CELLS  = COLS * LINES;
  // A scroll reads and rewrites the whole screen; random traffic causes on the order
  // of a hundred scrolls, plus the clearing pass. The limit allows several times that.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_REQS  = 200;
  localparam int PHASES      = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  tcc_req_t   req = '0;
  logic       done;
  tcc_rsp_t   rsp;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;

  // Shadow of the console state
  logic [15:0] shadow_screen [0:CELLS-1];
  int          shadow_col;
  int          shadow_row;
  logic [7:0]  shadow_color;

  tcc_rsp_t    rsp_due_q [$];
  tcc_rsp_t    want_rsp;
  int          mismatches = 0;
  int          cycle_count;
  int          burst_left = 0;

  text_console_cursor_scroll_core #(
    .COLUMNS(COLS),
    .ROWS   (LINES)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Wrap past the last column, then scroll past the last row
  function automatic void shadow_settle();
    if (shadow_col >= COLS) begin
      shadow_col = 0;
      shadow_row++;
    end
    if (shadow_row >= LINES) begin
      for (int k = 0; k < CELLS - COLS; k++) shadow_screen[k] = shadow_screen[k + COLS];
      for (int k = CELLS - COLS; k < CELLS; k++) shadow_screen[k] = {shadow_color, CH_SPACE};
      shadow_row = LINES - 1;
    end
  endfunction

  function automatic void shadow_put(logic [7:0] ch);
    int pos;
    pos = shadow_row * COLS + shadow_col;
    if (pos < CELLS) shadow_screen[pos] = {shadow_color, ch};
    shadow_col++;
    shadow_settle();
  endfunction

  // Apply one accepted request to the shadow and return its result
  function automatic tcc_rsp_t console_apply(tcc_req_t r);
    tcc_rsp_t res;
    res = '0;
    if (r.func == FUNC_WRITE) begin
      case (r.char_code)
        CH_BS: begin
          if (shadow_col > 0) begin
            shadow_col--;
          end else if (shadow_row > 0) begin
            shadow_row--;
            shadow_col = COLS - 1;
          end
          shadow_settle();
        end
        CH_TAB: begin
          repeat (TAB_SPACES) shadow_put(CH_SPACE);
        end
        CH_NL: begin
          shadow_col = 0;
          shadow_row++;
          shadow_settle();
        end
        default: begin
          shadow_put(r.char_code);
        end
      endcase
    end else if (r.cell_index < CELLS) begin
      res.cell_word = shadow_screen[r.cell_index];
    end
    res.cursor_col = 7'(shadow_col);
    res.cursor_row = 5'(shadow_row);
    res.write_done = r.end_of_write;
    return res;
  endfunction

  function automatic tcc_req_t mk_write(logic [7:0] ch, logic eow);
    tcc_req_t r;
    r.func         = FUNC_WRITE;
    r.char_code    = ch;
    r.cell_index   = 11'($urandom_range(0, 2047));
    r.end_of_write = eow;
    return r;
  endfunction

  function automatic tcc_req_t mk_read(int idx, logic eow);
    tcc_req_t r;
    r.func         = FUNC_READ;
    r.char_code    = 8'($urandom_range(0, 255));
    r.cell_index   = 11'(idx);
    r.end_of_write = eow;
    return r;
  endfunction

  // Hold the request until the core takes it, then record its result
  task automatic send_req(tcc_req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    rsp_due_q.push_back(console_apply(r));
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Pace requests in bursts with random gaps; some bursts run long and tight
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      burst_left = $urandom_range(20, 60);
    end else begin
      burst_left = $urandom_range(1, 12);
      idle_cycles($urandom_range(1, 9));
    end
  endtask

  // Drop start and wait until every result is in and the core is idle
  task automatic wait_idle();
    start <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_text_color(logic [7:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    shadow_color = value;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result with the oldest pending one
  always @(posedge clk) begin
    if (!rst && done) begin
      if (rsp_due_q.size() == 0) begin
        $display("%0t ns: result with none pending, expected none actual %p", $time, rsp);
        mismatches++;
      end else begin
        want_rsp = rsp_due_q.pop_front();
        check_field("cell_word", want_rsp.cell_word, rsp.cell_word);
        check_field("cursor_col", want_rsp.cursor_col, rsp.cursor_col);
        check_field("cursor_row", want_rsp.cursor_row, rsp.cursor_row);
        check_field("write_done", want_rsp.write_done, rsp.write_done);
      end
    end
  end

  // Reset contents, out-of-range reads, backspace at the top-left cell
  task automatic test_reset_screen();
    send_req(mk_read(0, 1'b0));
    send_req(mk_read(CELLS - 1, 1'b1));
    send_req(mk_read(CELLS, 1'b0));
    send_req(mk_read(2047, 1'b1));
    send_req(mk_write(CH_BS, 1'b1));
  endtask

  // Plain bytes at the extremes, carriage return stored as a cell
  task automatic test_plain_chars();
    send_req(mk_write(8'h41, 1'b0));
    send_req(mk_write(8'h00, 1'b0));
    send_req(mk_write(8'hFF, 1'b0));
    send_req(mk_write(8'h0D, 1'b1));
    send_req(mk_read(2, 1'b0));
  endtask

  // Backspace, tab, newline, backspace across a row, wrap on the last column
  task automatic test_cursor_moves();
    send_req(mk_write(CH_BS, 1'b0));
    send_req(mk_write(CH_TAB, 1'b0));
    send_req(mk_write(CH_NL, 1'b0));
    send_req(mk_write(CH_BS, 1'b0));
    send_req(mk_write(8'h5A, 1'b1));
    send_req(mk_read(COLS - 1, 1'b0));
  endtask

  // Walk down to the bottom row, scroll with a new color, tab on the bottom
  task automatic test_scroll();
    wait_idle();
    set_text_color(8'hFF);
    while (shadow_row < LINES - 1) send_req(mk_write(CH_NL, 1'b0));
    send_req(mk_write(CH_NL, 1'b1));
    send_req(mk_read(CELLS - COLS, 1'b0));
    send_req(mk_write(CH_TAB, 1'b1));
  endtask

  function automatic logic [7:0] pick_char();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 8'($urandom_range(8'h20, 8'h7E));
    if (p < 76) return CH_BS;
    if (p < 80) return CH_TAB;
    if (p < 83) return CH_NL;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_index();
    int p;
    p = $urandom_range(0, 9);
    if (p < 5) return shadow_row * COLS + $urandom_range(0, COLS - 1);
    if (p < 9) return $urandom_range(0, CELLS - 1);
    return $urandom_range(0, 2047);
  endfunction

  // Write calls of random text mixed with cell reads, one color per phase
  task automatic test_random_traffic();
    int sent;
    int call_len;
    logic [7:0] color;
    logic eow;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       color = 8'h00;
        1:       color = 8'hFF;
        2:       color = COLOR_RESET;
        default: color = 8'($urandom_range(0, 255));
      endcase
      set_text_color(color);
      sent = 0;
      while (sent < PHASE_REQS) begin
        if ($urandom_range(0, 99) < 15) begin
          send_req(mk_read(pick_index(), 1'($urandom_range(0, 1))));
          pace();
          sent++;
        end else begin
          call_len = $urandom_range(1, 40);
          for (int i = 0; i < call_len; i++) begin
            eow = (i == call_len - 1);
            // flip the call marker now and then
            if ($urandom_range(0, 19) == 0) eow = ~eow;
            send_req(mk_write(pick_char(), eow));
            pace();
            sent++;
          end
        end
        if ($urandom_range(0, 49) == 0) wait_idle();
      end
    end
  endtask

  // Stop a hung run
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("tb_text_console_cursor_scroll_core failed");
    $finish;
  end

  initial begin
    for (int k = 0; k < CELLS; k++) shadow_screen[k] = CELL_RESET;
    shadow_col   = 0;
    shadow_row   = 0;
    shadow_color = COLOR_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_screen();
    test_plain_chars();
    test_cursor_moves();
    test_scroll();
    test_random_traffic();

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_text_console_cursor_scroll_core passed");
    end else begin
      $display("tb_text_console_cursor_scroll_core failed");
    end
    $finish;
  end

endmodule
